FILE: hw/rtl/lmc_pkg.sv
// Shared types and constants for the LED matrix chain row controller.
// Used by lmc_ctrl, lmc_datapath and the top level; depends on nothing.

package lmc_pkg;

  typedef enum logic [3:0] {
    CMD_SET       = 4'd0,
    CMD_STORE     = 4'd1,
    CMD_OVERLAY   = 4'd2,
    CMD_RESTORE   = 4'd3,
    CMD_XOR       = 4'd4,
    CMD_REFRESH   = 4'd5,
    CMD_CLEAR     = 4'd6,
    CMD_SCAN      = 4'd7,
    CMD_INTENSITY = 4'd8,
    CMD_POWER     = 4'd9,
    CMD_WAKEALL   = 4'd10,
    CMD_DIRECT    = 4'd11,
    CMD_INIT      = 4'd12
  } cmd_t;

  localparam logic [3:0] REG_DECODE    = 4'd9;
  localparam logic [3:0] REG_INTENSITY = 4'd10;
  localparam logic [3:0] REG_SCAN      = 4'd11;
  localparam logic [3:0] REG_SHUTDOWN  = 4'd12;
  localparam logic [3:0] REG_TEST      = 4'd15;

  localparam logic [3:0] COUNT_RESET   = 4'd12;
  localparam logic [7:0] ROW_ON        = 8'hFF;
  localparam logic [7:0] SCAN_ALL      = 8'h07;

  typedef struct packed {
    logic load;
    logic wr_en;
    logic rd_en;
    logic out_load;
    logic advance;
  } dp_ctl_t;

  typedef struct packed {
    logic empty;
    logic emit;
    logic wr;
    logic rd;
    logic last;
  } dp_sts_t;

endpackage

FILE: hw/rtl/lmc_datapath.sv
// Datapath of the LED matrix chain row controller: command registers, slot
// decode, shadow row memory with valid bits and the output register.
// Depends on lmc_pkg.

module lmc_datapath import lmc_pkg::*; #(
  parameter int MAX_DEVICES = 12
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [3:0] cfg_wdata,
  input  logic [3:0] command,
  input  logic [3:0] device,
  input  logic [2:0] row,
  input  logic [7:0] value,
  input  dp_ctl_t    ctl,
  output dp_sts_t    sts,
  output logic [3:0] target_device,
  output logic [3:0] register_code,
  output logic [7:0] payload,
  output logic       last
);

  localparam int DEPTH  = MAX_DEVICES * 8;
  localparam int ADDR_W = $clog2(DEPTH);

  logic [3:0] device_count;
  cmd_t       cmd;
  logic [3:0] dev;
  logic [2:0] row_r;
  logic [7:0] val;
  logic [3:0] k;
  logic [4:0] a;

  logic [7:0]       mem [DEPTH];
  logic [DEPTH-1:0] vld;
  logic [7:0]       rd_data;
  logic             rd_vld;
  logic [7:0]       shadow;

  logic [4:0]        cnt;
  logic              dev_ok;
  logic [4:0]        stride;
  logic [4:0]        a_step;
  logic [4:0]        a_one;
  logic [4:0]        dev_next;
  logic [3:0]        row_code;
  logic [3:0]        s_adev;
  logic [2:0]        s_arow;
  logic [7:0]        s_wdata;
  logic [3:0]        s_dev;
  logic [3:0]        s_reg;
  logic [7:0]        s_pay;
  logic [ADDR_W-1:0] mem_addr;

  assign cnt = (device_count == 4'd0 || {1'b0, device_count} > 5'(MAX_DEVICES))
             ? 5'(MAX_DEVICES) : {1'b0, device_count};
  assign dev_ok   = {1'b0, dev} < cnt;
  assign stride   = (val > 8'd1) ? 5'd1 : 5'd2;
  assign a_step   = a + stride;
  assign a_one    = a + 5'd1;
  assign dev_next = {1'b0, dev} + 5'd1;
  assign row_code = {1'b0, row_r} + 4'd1;
  assign shadow   = rd_vld ? rd_data : 8'h00;
  assign mem_addr = ADDR_W'({s_adev, s_arow});

  always_comb begin
    sts     = '0;
    s_adev  = dev;
    s_arow  = row_r;
    s_wdata = 8'h00;
    s_dev   = dev;
    s_reg   = row_code;
    s_pay   = 8'h00;
    case (cmd)
      CMD_SET: begin
        sts.empty = !dev_ok;
        sts.wr    = 1'b1;
        sts.emit  = 1'b1;
        sts.last  = 1'b1;
        s_wdata   = val;
        s_pay     = val;
      end
      CMD_STORE: begin
        sts.empty = !dev_ok;
        sts.wr    = 1'b1;
        sts.last  = 1'b1;
        s_wdata   = val;
      end
      CMD_OVERLAY: begin
        sts.empty = !dev_ok;
        sts.emit  = 1'b1;
        sts.last  = 1'b1;
        s_pay     = val;
      end
      CMD_RESTORE: begin
        sts.empty = !dev_ok;
        sts.rd    = 1'b1;
        sts.emit  = 1'b1;
        sts.last  = 1'b1;
        s_pay     = shadow;
      end
      CMD_XOR: begin
        sts.empty = !dev_ok;
        sts.rd    = 1'b1;
        sts.emit  = 1'b1;
        sts.last  = 1'b1;
        s_pay     = shadow ^ val;
      end
      CMD_REFRESH: begin
        sts.empty = a >= cnt;
        sts.rd    = 1'b1;
        sts.emit  = 1'b1;
        sts.last  = a_step >= cnt;
        s_adev    = a[3:0];
        s_dev     = a[3:0];
        s_pay     = shadow;
      end
      CMD_CLEAR: begin
        sts.empty = !dev_ok;
        sts.wr    = 1'b1;
        sts.emit  = 1'b1;
        sts.last  = k == 4'd7;
        s_arow    = k[2:0];
        s_reg     = k + 4'd1;
      end
      CMD_SCAN: begin
        sts.empty = !dev_ok || val > SCAN_ALL;
        sts.emit  = 1'b1;
        sts.last  = 1'b1;
        s_reg     = REG_SCAN;
        s_pay     = val;
      end
      CMD_INTENSITY: begin
        sts.empty = !dev_ok || val > 8'd15;
        sts.emit  = 1'b1;
        sts.last  = 1'b1;
        s_reg     = REG_INTENSITY;
        s_pay     = val;
      end
      CMD_POWER: begin
        sts.empty = !dev_ok;
        sts.emit  = 1'b1;
        sts.last  = 1'b1;
        s_reg     = REG_SHUTDOWN;
        s_pay     = {7'd0, val != 8'd0};
      end
      CMD_WAKEALL: begin
        sts.emit  = 1'b1;
        sts.last  = a_one >= cnt;
        s_dev     = a[3:0];
        s_reg     = REG_SHUTDOWN;
        s_pay     = 8'h01;
      end
      CMD_DIRECT: begin
        sts.empty = !dev_ok;
        sts.emit  = 1'b1;
        if (k == 4'd0) begin
          sts.last = !(dev_next < cnt);
          s_pay    = (val != 8'd0) ? ROW_ON : 8'h00;
        end else begin
          sts.last = 1'b1;
          s_dev    = dev_next[3:0];
          s_reg    = REG_SHUTDOWN;
          s_pay    = {7'd0, val == 8'd0};
        end
      end
      CMD_INIT: begin
        sts.empty = !dev_ok;
        sts.emit  = 1'b1;
        case (k)
          4'd0: s_reg = REG_TEST;
          4'd1: begin
            s_reg = REG_SCAN;
            s_pay = SCAN_ALL;
          end
          4'd2: s_reg = REG_DECODE;
          4'd11: begin
            s_reg    = REG_SHUTDOWN;
            sts.last = 1'b1;
          end
          default: begin
            sts.wr = 1'b1;
            s_arow = 3'(k - 4'd3);
            s_reg  = k - 4'd2;
          end
        endcase
      end
      default: begin
        sts.empty = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      device_count <= COUNT_RESET;
    end else if (cfg_we) begin
      device_count <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd   <= cmd_t'(command);
      dev   <= device;
      row_r <= row;
      val   <= value;
      k     <= 4'd0;
      a     <= (cmd_t'(command) == CMD_REFRESH && value <= 8'd1) ? {4'd0, value[0]} : 5'd0;
    end else if (ctl.advance) begin
      k <= k + 4'd1;
      a <= (cmd == CMD_REFRESH) ? a_step : a_one;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[mem_addr] <= s_wdata;
    end
    if (ctl.rd_en) begin
      rd_data <= mem[mem_addr];
      rd_vld  <= vld[mem_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (ctl.wr_en) begin
      vld[mem_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      target_device <= s_dev;
      register_code <= s_reg;
      payload       <= s_pay;
      last          <= sts.last;
    end
  end

endmodule

FILE: hw/rtl/lmc_ctrl.sv
// Controller of the LED matrix chain row controller: steps through the
// transfers of one command and owns both handshakes. Depends on lmc_pkg.

module lmc_ctrl import lmc_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_stall,
  output logic    out_valid,
  input  logic    out_stall,
  input  dp_sts_t sts,
  output dp_ctl_t ctl
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SLOT,
    ST_EMIT
  } state_t;

  state_t state;
  logic   out_free;

  assign in_stall = state != ST_IDLE;
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    ctl          = '0;
    ctl.load     = state == ST_IDLE && in_valid;
    ctl.wr_en    = state == ST_SLOT && sts.wr;
    ctl.rd_en    = state == ST_SLOT && sts.rd;
    ctl.out_load = state == ST_EMIT && out_free;
    ctl.advance  = (state == ST_SLOT && !sts.emit) || ctl.out_load;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (ctl.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            state <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          state <= sts.empty ? ST_IDLE : ST_SLOT;
        end
        ST_SLOT: begin
          if (sts.emit) begin
            state <= ST_EMIT;
          end else if (sts.last) begin
            state <= ST_IDLE;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            state <= sts.last ? ST_IDLE : ST_SLOT;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: hw/rtl/led_matrix_chain_row_controller_top.sv
// Top level of the LED matrix chain row controller; instantiates lmc_ctrl
// and lmc_datapath and depends on lmc_pkg.
//
// Each accepted command expands into its register transfers, one result per
// transfer with last set on the final one; commands that send nothing give no
// result. A command is taken in from the idle state and checked in the check
// state; each transfer then passes through the slot state (shadow memory
// access and slot decode) and the emit state (loading the output register),
// which waits while the output is stalled. The shadow store has a valid bit
// per entry, cleared by reset, so no clearing pass runs. The next command is
// accepted as soon as the last transfer is in the output register.

module led_matrix_chain_row_controller_top import lmc_pkg::*; #(
  parameter int MAX_DEVICES = 12
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [3:0] cfg_wdata,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [3:0] command,
  input  logic [3:0] device,
  input  logic [2:0] row,
  input  logic [7:0] value,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [3:0] target_device,
  output logic [3:0] register_code,
  output logic [7:0] payload,
  output logic       last
);

  dp_ctl_t ctl;
  dp_sts_t sts;

  lmc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .ctl       (ctl)
  );

  lmc_datapath #(
    .MAX_DEVICES (MAX_DEVICES)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .command       (command),
    .device        (device),
    .row           (row),
    .value         (value),
    .ctl           (ctl),
    .sts           (sts),
    .target_device (target_device),
    .register_code (register_code),
    .payload       (payload),
    .last          (last)
  );

endmodule
